/* rtl/core/ctbf_pkg.sv */
// cross-template box filter: shared sizes, register codes and transaction types
// no dependencies
package ctbf_pkg;

  localparam int MAX_LINE_WIDTH   = 1024;
  localparam int MAX_WINDOW       = 32;
  localparam int MAX_FRAME_HEIGHT = 4096;
  localparam int PIXEL_BITS       = 16;

  localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W   = $clog2(MAX_FRAME_HEIGHT);
  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int CSUM_W  = PIXEL_BITS + SLOT_W;
  localparam int WSUM_W  = CSUM_W + SLOT_W;
  localparam int SCORE_W = 29;

  // raw register widths
  localparam int FW_W = 11;
  localparam int FH_W = 13;
  localparam int WS_W = 6;
  localparam int CS_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // adder tree grouping
  localparam int GRP  = 8;
  localparam int NGRP = (MAX_WINDOW + GRP - 1) / GRP;

  // queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_WINDOW_SIZE,
    REG_CORNER_SIZE
  } cfg_reg_t;

  // clamped settings
  typedef struct packed {
    logic [COL_W:0] w;
    logic [ROW_W:0] h;
    logic [WS_W-1:0] ws;
    logic [WS_W-1:0] cs;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] wcol;
    logic [ROW_W-1:0] wrow;
    logic             valid;
    logic             eof;
  } pos_t;

  typedef struct packed {
    logic [CSUM_W-1:0] full;
    logic [CSUM_W-1:0] top;
    logic [CSUM_W-1:0] bot;
    pos_t              pos;
  } col_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COL_W-1:0]   wcol;
    logic [ROW_W-1:0]   wrow;
    logic               valid;
    logic               eof;
  } res_item_t;

endpackage

/* rtl/core/ctbf_queue.sv */
// short queue of column-sum transactions between front and back
// depends on ctbf_pkg
module ctbf_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  ctbf_pkg::col_item_t        push_item,
  input  logic                       pop,
  output ctbf_pkg::col_item_t        head,
  output logic [ctbf_pkg::QCNT_W-1:0] count
);

  ctbf_pkg::col_item_t             buf_q [ctbf_pkg::QDEPTH];
  logic [ctbf_pkg::QPTR_W-1:0]     wp;
  logic [ctbf_pkg::QPTR_W-1:0]     rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + ctbf_pkg::QCNT_W'(push) - ctbf_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_q[wp] <= push_item;
  end

  assign head = buf_q[rp];

endmodule

/* rtl/core/ctbf_front.sv */
// front: takes pixels, keeps position, row banks and per-column band sums
// depends on ctbf_pkg
module ctbf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  ctbf_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  input  logic [ctbf_pkg::PIXEL_BITS-1:0]     pixel,
  output logic                                in_stall,
  input  logic [ctbf_pkg::QCNT_W-1:0]         q_count,
  output logic                                push,
  output ctbf_pkg::col_item_t                 push_item
);

  localparam int CW = ctbf_pkg::COL_W;
  localparam int RW = ctbf_pkg::ROW_W;
  localparam int SW = ctbf_pkg::SLOT_W;
  localparam int MW = ctbf_pkg::MAX_WINDOW;
  localparam int PW = ctbf_pkg::PIXEL_BITS;
  localparam int SUMW = ctbf_pkg::CSUM_W;

  logic            accept;
  logic [CW-1:0]   col_cnt;
  logic [RW-1:0]   row_cnt;
  logic [CW:0]     col1;
  logic [RW:0]     row1;
  logic            last_col;
  logic            last_row;
  ctbf_pkg::pos_t  pos_new;

  // registered read data, one word per row bank
  logic [PW-1:0]   rd [MW];

  logic            f0_v;
  logic [PW-1:0]   f0_pix;
  logic [RW-1:0]   f0_row;
  ctbf_pkg::pos_t  f0_pos;

  logic            f1_v;
  ctbf_pkg::pos_t  f1_pos;
  logic [SUMW-1:0] f1_full [ctbf_pkg::NGRP];
  logic [SUMW-1:0] f1_top  [ctbf_pkg::NGRP];
  logic [SUMW-1:0] f1_bot  [ctbf_pkg::NGRP];

  logic [SUMW-1:0] g_full [ctbf_pkg::NGRP];
  logic [SUMW-1:0] g_top  [ctbf_pkg::NGRP];
  logic [SUMW-1:0] g_bot  [ctbf_pkg::NGRP];

  assign in_stall = ((ctbf_pkg::QCNT_W+1)'(q_count) + (ctbf_pkg::QCNT_W+1)'(f0_v)
                     + (ctbf_pkg::QCNT_W+1)'(f1_v)) >= (ctbf_pkg::QCNT_W+1)'(ctbf_pkg::QDEPTH);
  assign accept = in_valid && !in_stall;

  always_comb begin
    col1     = (CW+1)'(col_cnt) + 1'b1;
    row1     = (RW+1)'(row_cnt) + 1'b1;
    last_col = col1 >= cfg.w;
    last_row = row1 >= cfg.h;
    pos_new.col   = col_cnt;
    pos_new.valid = (row1 >= (RW+1)'(cfg.ws)) && (col1 >= (CW+1)'(cfg.ws))
                 && (((CW+2)'(col1) + 1'b1) <= (CW+2)'(cfg.w))
                 && (((RW+2)'(row1) + 1'b1) <= (RW+2)'(cfg.h));
    pos_new.wcol  = pos_new.valid ? CW'(col1 - (CW+1)'(cfg.ws)) : '0;
    pos_new.wrow  = pos_new.valid ? RW'(row1 - (RW+1)'(cfg.ws)) : '0;
    pos_new.eof   = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      f0_v    <= 1'b0;
      f1_v    <= 1'b0;
    end else begin
      f0_v <= accept;
      f1_v <= f0_v;
      if (accept) begin
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= last_row ? '0 : RW'(row1);
        end else begin
          col_cnt <= CW'(col1);
        end
      end
    end
  end

  // one bank per row slot; write and read in the accept cycle, own bank is bypassed later
  for (genvar k = 0; k < MW; k++) begin : g_bank
    logic [PW-1:0] mem [ctbf_pkg::MAX_LINE_WIDTH];

    always_ff @(posedge clk) begin
      if (accept && row_cnt[SW-1:0] == SW'(k)) mem[col_cnt] <= pixel;
      if (accept) rd[k] <= mem[col_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f0_pix <= pixel;
      f0_row <= row_cnt;
      f0_pos <= pos_new;
    end
  end

  // masked group sums over the row slots
  always_comb begin
    logic [SW-1:0] rslot;
    logic [SW-1:0] d;
    logic          armed;
    logic          in_w;
    logic [PW-1:0] val;
    int            idx;
    rslot = f0_row[SW-1:0];
    armed = ((RW+1)'(f0_row) + 1'b1) >= (RW+1)'(cfg.ws);
    for (int g = 0; g < ctbf_pkg::NGRP; g++) begin
      g_full[g] = '0;
      g_top[g]  = '0;
      g_bot[g]  = '0;
      for (int j = 0; j < ctbf_pkg::GRP; j++) begin
        idx = g * ctbf_pkg::GRP + j;
        if (idx < MW) begin
          d    = SW'(rslot - SW'(idx));
          val  = (SW'(idx) == rslot) ? f0_pix : rd[idx];
          in_w = armed && ((ctbf_pkg::WS_W)'(d) < cfg.ws);
          if (in_w) g_full[g] = g_full[g] + SUMW'(val);
          if (in_w && (ctbf_pkg::WS_W)'(d) >= (cfg.ws - cfg.cs))
            g_top[g] = g_top[g] + SUMW'(val);
          if (in_w && (ctbf_pkg::WS_W)'(d) < cfg.cs)
            g_bot[g] = g_bot[g] + SUMW'(val);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f0_v) begin
      f1_pos  <= f0_pos;
      f1_full <= g_full;
      f1_top  <= g_top;
      f1_bot  <= g_bot;
    end
  end

  always_comb begin
    push_item.full = '0;
    push_item.top  = '0;
    push_item.bot  = '0;
    for (int g = 0; g < ctbf_pkg::NGRP; g++) begin
      push_item.full = push_item.full + f1_full[g];
      push_item.top  = push_item.top + f1_top[g];
      push_item.bot  = push_item.bot + f1_bot[g];
    end
    push_item.pos = f1_pos;
  end

  assign push = f1_v;

endmodule

/* rtl/core/ctbf_back.sv */
// back: ring of recent column sums, window and corner sums, result buffer
// depends on ctbf_pkg
module ctbf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ctbf_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  ctbf_pkg::col_item_t  q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctbf_pkg::res_item_t  out_item
);

  localparam int SW   = ctbf_pkg::SLOT_W;
  localparam int MW   = ctbf_pkg::MAX_WINDOW;
  localparam int CSW  = ctbf_pkg::CSUM_W;
  localparam int WSW  = ctbf_pkg::WSUM_W;
  localparam int SCW  = ctbf_pkg::SCORE_W;
  localparam int NG   = ctbf_pkg::NGRP;

  logic [CSW-1:0] ring_full [MW];
  logic [CSW-1:0] ring_top  [MW];
  logic [CSW-1:0] ring_bot  [MW];

  // sums: 0 window, 1 top-left, 2 top-right, 3 bottom-left, 4 bottom-right
  logic [WSW-1:0] g_sum  [5][NG];
  logic [WSW-1:0] b0_sum [5][NG];
  logic [WSW-1:0] tot    [5];
  logic           b0_v;
  ctbf_pkg::pos_t b0_pos;

  ctbf_pkg::res_item_t          res;
  ctbf_pkg::res_item_t          obuf [ctbf_pkg::QDEPTH];
  logic [ctbf_pkg::QPTR_W-1:0]  owp;
  logic [ctbf_pkg::QPTR_W-1:0]  orp;
  logic [ctbf_pkg::QCNT_W-1:0]  ocnt;
  logic                         out_pop;

  assign pop = q_valid && (((ctbf_pkg::QCNT_W+1)'(ocnt) + (ctbf_pkg::QCNT_W+1)'(b0_v))
                           < (ctbf_pkg::QCNT_W+1)'(ctbf_pkg::QDEPTH));

  always_comb begin
    logic [SW-1:0]  cslot;
    logic [SW-1:0]  d;
    logic [CSW-1:0] vf;
    logic [CSW-1:0] vt;
    logic [CSW-1:0] vb;
    logic           in_w;
    logic           lo;
    logic           hi;
    int             idx;
    cslot = q_item.pos.col[SW-1:0];
    for (int g = 0; g < NG; g++) begin
      for (int n = 0; n < 5; n++) g_sum[n][g] = '0;
      for (int j = 0; j < ctbf_pkg::GRP; j++) begin
        idx = g * ctbf_pkg::GRP + j;
        if (idx < MW) begin
          d    = SW'(cslot - SW'(idx));
          vf   = (SW'(idx) == cslot) ? q_item.full : ring_full[idx];
          vt   = (SW'(idx) == cslot) ? q_item.top  : ring_top[idx];
          vb   = (SW'(idx) == cslot) ? q_item.bot  : ring_bot[idx];
          in_w = (ctbf_pkg::WS_W)'(d) < cfg.ws;
          lo   = in_w && (ctbf_pkg::WS_W)'(d) >= (cfg.ws - cfg.cs);
          hi   = in_w && (ctbf_pkg::WS_W)'(d) < cfg.cs;
          if (in_w) g_sum[0][g] = g_sum[0][g] + WSW'(vf);
          if (lo)   g_sum[1][g] = g_sum[1][g] + WSW'(vt);
          if (hi)   g_sum[2][g] = g_sum[2][g] + WSW'(vt);
          if (lo)   g_sum[3][g] = g_sum[3][g] + WSW'(vb);
          if (hi)   g_sum[4][g] = g_sum[4][g] + WSW'(vb);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ring_full[q_item.pos.col[SW-1:0]] <= q_item.full;
      ring_top[q_item.pos.col[SW-1:0]]  <= q_item.top;
      ring_bot[q_item.pos.col[SW-1:0]]  <= q_item.bot;
      b0_sum <= g_sum;
      b0_pos <= q_item.pos;
    end
  end

  always_comb begin
    for (int n = 0; n < 5; n++) begin
      tot[n] = '0;
      for (int g = 0; g < NG; g++) tot[n] = tot[n] + b0_sum[n][g];
    end
    res.score = b0_pos.valid ? (SCW'(tot[0]) - SCW'(tot[1]) - SCW'(tot[2])
                                - SCW'(tot[3]) - SCW'(tot[4])) : '0;
    res.wcol  = b0_pos.wcol;
    res.wrow  = b0_pos.wrow;
    res.valid = b0_pos.valid;
    res.eof   = b0_pos.eof;
  end

  assign out_valid = ocnt != '0;
  assign out_pop   = out_valid && !out_stall;
  assign out_item  = obuf[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      b0_v <= pop;
      if (b0_v) owp <= owp + 1'b1;
      if (out_pop) orp <= orp + 1'b1;
      ocnt <= ocnt + ctbf_pkg::QCNT_W'(b0_v) - ctbf_pkg::QCNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b0_v) obuf[owp] <= res;
  end

endmodule

/* rtl/core/cross_template_box_filter_core.sv */
// cross-template box filter top level: registers, front, queue, back
// depends on ctbf_pkg, ctbf_front, ctbf_queue, ctbf_back
//
// Pixels enter in raster order, one transaction per clock at full rate while
// in_stall is low, and each gives exactly one result transaction: the score
// of the square window whose bottom-right pixel is that pixel, i.e. the
// window sum minus its four corner squares. A result passes through two
// front stages that read the 32 row banks and sum each column's full, top
// and bottom bands, then one queue slot, one back stage that sums the column
// ring into the window and corner sums, and the result buffer. Both queues
// are 4 deep, so either side may stall without stopping the other at once.
// The row banks need no clearing pass after reset; a window only reads
// rows of the current frame. Registers are written through cfg_write /
// cfg_index / cfg_data and must only change while no transaction is in
// flight.
module cross_template_box_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ctbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctbf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ctbf_pkg::PIXEL_BITS-1:0]     pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ctbf_pkg::SCORE_W-1:0] score,
  output logic [ctbf_pkg::COL_W-1:0]          window_col,
  output logic [ctbf_pkg::ROW_W-1:0]          window_row,
  output logic                                score_valid,
  output logic                                end_of_frame
);

  // raw register values
  logic [ctbf_pkg::FW_W-1:0] frame_width;
  logic [ctbf_pkg::FH_W-1:0] frame_height;
  logic [ctbf_pkg::WS_W-1:0] window_size;
  logic [ctbf_pkg::CS_W-1:0] corner_size;

  ctbf_pkg::cfg_t             cfg;
  logic                       q_push;
  ctbf_pkg::col_item_t        q_push_item;
  logic                       q_pop;
  ctbf_pkg::col_item_t        q_head;
  logic [ctbf_pkg::QCNT_W-1:0] q_count;
  ctbf_pkg::res_item_t        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ctbf_pkg::FW_W'(1024);
      frame_height <= ctbf_pkg::FH_W'(1024);
      window_size  <= ctbf_pkg::WS_W'(15);
      corner_size  <= ctbf_pkg::CS_W'(5);
    end else if (cfg_write) begin
      case (ctbf_pkg::cfg_reg_t'(cfg_index))
        ctbf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[ctbf_pkg::FW_W-1:0];
        ctbf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[ctbf_pkg::FH_W-1:0];
        ctbf_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[ctbf_pkg::WS_W-1:0];
        ctbf_pkg::REG_CORNER_SIZE:  corner_size  <= cfg_data[ctbf_pkg::CS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to legal ranges; zero width, height or window acts as one, corner never exceeds window
  always_comb begin
    if (frame_width == '0) cfg.w = (ctbf_pkg::COL_W+1)'(1);
    else if (32'(frame_width) > ctbf_pkg::MAX_LINE_WIDTH)
      cfg.w = (ctbf_pkg::COL_W+1)'(ctbf_pkg::MAX_LINE_WIDTH);
    else cfg.w = (ctbf_pkg::COL_W+1)'(frame_width);

    if (frame_height == '0) cfg.h = (ctbf_pkg::ROW_W+1)'(1);
    else if (32'(frame_height) > ctbf_pkg::MAX_FRAME_HEIGHT)
      cfg.h = (ctbf_pkg::ROW_W+1)'(ctbf_pkg::MAX_FRAME_HEIGHT);
    else cfg.h = (ctbf_pkg::ROW_W+1)'(frame_height);

    if (window_size == '0) cfg.ws = ctbf_pkg::WS_W'(1);
    else if (32'(window_size) > ctbf_pkg::MAX_WINDOW)
      cfg.ws = ctbf_pkg::WS_W'(ctbf_pkg::MAX_WINDOW);
    else cfg.ws = window_size;

    cfg.cs = (corner_size > cfg.ws) ? cfg.ws : corner_size;
  end

  // front: position tracking, row banks, column band sums
  ctbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .pixel     (pixel),
    .in_stall  (in_stall),
    .q_count   (q_count),
    .push      (q_push),
    .push_item (q_push_item)
  );

  // decouples the two halves
  ctbf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count)
  );

  // back: window and corner sums, score, result buffer
  ctbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_count != '0),
    .q_item    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (res)
  );

  assign score        = res.score;
  assign window_col   = res.wcol;
  assign window_row   = res.wrow;
  assign score_valid  = res.valid;
  assign end_of_frame = res.eof;

  // queue never goes past its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ctbf_pkg::QCNT_W'(ctbf_pkg::QDEPTH))
    else $error("column queue overflow");

  // a full queue must hold off new pixels
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (q_count == ctbf_pkg::QCNT_W'(ctbf_pkg::QDEPTH)) |-> in_stall)
    else $error("pixel taken with column queue full");

  // nothing popped from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("pop from empty column queue");

  // an unscored window carries zeros
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !score_valid) |-> (score == '0 && window_col == '0 && window_row == '0))
    else $error("unscored result carries nonzero fields");

endmodule

/* verif/testbench.sv */
// self-checking testbench for cross_template_box_filter_core: random and directed frames
// depends on ctbf_pkg and the rtl core; the score predictor is kept in this file
`timescale 1ns / 100ps

module testbench;

  // one result transaction as the block should give it
  typedef struct {
    logic [ctbf_pkg::SCORE_W-1:0] score;
    logic [ctbf_pkg::COL_W-1:0]   wcol;
    logic [ctbf_pkg::ROW_W-1:0]   wrow;
    logic                         valid;
    logic                         eof;
  } score_rec_t;

  // pixel content of a stimulus frame
  typedef enum int {
    FILL_RANDOM,
    FILL_FULL,
    FILL_ZERO,
    FILL_EXTREME
  } fill_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic [ctbf_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [ctbf_pkg::CFG_DATA_W-1:0]     cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [ctbf_pkg::PIXEL_BITS-1:0]     pixel;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [ctbf_pkg::SCORE_W-1:0] score;
  logic [ctbf_pkg::COL_W-1:0]          window_col;
  logic [ctbf_pkg::ROW_W-1:0]          window_row;
  logic                                score_valid;
  logic                                end_of_frame;

  cross_template_box_filter_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .score(score), .window_col(window_col), .window_row(window_row),
    .score_valid(score_valid), .end_of_frame(end_of_frame)
  );

  // predictor state: raw registers, line store, column ring, position
  int unsigned   reg_width, reg_height, reg_window, reg_corner;
  bit [15:0]     line_store [ctbf_pkg::MAX_WINDOW][ctbf_pkg::MAX_LINE_WIDTH];
  longint        col_ring [ctbf_pkg::MAX_WINDOW][3];
  int unsigned   next_col, next_row;

  score_rec_t    pending_scores[$];
  int            errors;
  int            pixels_sent;
  int            results_seen;
  int            valid_scores;
  int            frames_done;
  int            idle_cycles;
  bit            quiet;   // no idling on either side

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // next expected result for one accepted pixel; advances the position
  function automatic score_rec_t score_pixel(bit [15:0] pix);
    int unsigned w, h, ws, cs, col, row, cslot, top, left, s;
    longint      win_sum, c_tl, c_tr, c_bl, c_br, p;
    bit          ok, last_col, last_row;
    score_rec_t  r;
    w   = clamp_u(reg_width, 1, ctbf_pkg::MAX_LINE_WIDTH);
    h   = clamp_u(reg_height, 1, ctbf_pkg::MAX_FRAME_HEIGHT);
    ws  = clamp_u(reg_window, 1, ctbf_pkg::MAX_WINDOW);
    cs  = (reg_corner > ws) ? ws : reg_corner;
    col = next_col % ctbf_pkg::MAX_LINE_WIDTH;
    row = next_row % ctbf_pkg::MAX_FRAME_HEIGHT;
    cslot = col % ctbf_pkg::MAX_WINDOW;
    line_store[row % ctbf_pkg::MAX_WINDOW][col] = pix;
    // full, top band and bottom band sums of this column
    col_ring[cslot][0] = 0;
    col_ring[cslot][1] = 0;
    col_ring[cslot][2] = 0;
    if (row + 1 >= ws) begin
      top = row + 1 - ws;
      for (int i = 0; i < ws; i++) begin
        p = line_store[(top + i) % ctbf_pkg::MAX_WINDOW][col];
        col_ring[cslot][0] += p;
        if (i < cs) col_ring[cslot][1] += p;
        if (i >= ws - cs) col_ring[cslot][2] += p;
      end
    end
    ok = (row + 1 >= ws) && (col + 1 >= ws) && (col + 2 <= w) && (row + 2 <= h);
    r.score = '0;
    r.wcol  = '0;
    r.wrow  = '0;
    r.valid = ok;
    if (ok) begin
      left = col + 1 - ws;
      win_sum = 0; c_tl = 0; c_tr = 0; c_bl = 0; c_br = 0;
      for (int i = 0; i < ws; i++) begin
        s = (left + i) % ctbf_pkg::MAX_WINDOW;
        win_sum += col_ring[s][0];
        if (i < cs) begin
          c_tl += col_ring[s][1];
          c_bl += col_ring[s][2];
        end
        if (i >= ws - cs) begin
          c_tr += col_ring[s][1];
          c_br += col_ring[s][2];
        end
      end
      r.score = ctbf_pkg::SCORE_W'(win_sum - c_tl - c_tr - c_bl - c_br);
      r.wcol  = ctbf_pkg::COL_W'(left);
      r.wrow  = ctbf_pkg::ROW_W'(row + 1 - ws);
    end
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    r.eof = last_col && last_row;
    if (last_col) begin
      next_col = 0;
      next_row = last_row ? 0 : row + 1;
    end else begin
      next_col = col + 1;
    end
    return r;
  endfunction

  // sink side stall: random bursts, none once the run goes quiet
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // result checker: each result transaction against the oldest prediction
  always @(posedge clk) begin
    score_rec_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result score=%0d col=%0d row=%0d", $time,
                 score, window_col, window_row);
        errors++;
      end else begin
        e = pending_scores.pop_front();
        if (score !== e.score) begin
          $display("%0t: score expected %0d actual %0d", $time,
                   $signed(e.score), score);
          errors++;
        end
        if (window_col !== e.wcol) begin
          $display("%0t: window_col expected %0d actual %0d", $time, e.wcol, window_col);
          errors++;
        end
        if (window_row !== e.wrow) begin
          $display("%0t: window_row expected %0d actual %0d", $time, e.wrow, window_row);
          errors++;
        end
        if (score_valid !== e.valid) begin
          $display("%0t: score_valid expected %0b actual %0b", $time, e.valid, score_valid);
          errors++;
        end
        if (end_of_frame !== e.eof) begin
          $display("%0t: end_of_frame expected %0b actual %0b", $time, e.eof, end_of_frame);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("cross_template_box_filter_core test failed");
      $finish;
    end
  end

  // one pixel transaction, with an occasional random gap in front of it
  task automatic send_pixel(bit [15:0] pix);
    score_rec_t e;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= pix;
    do @(posedge clk); while (in_stall);
    e = score_pixel(pix);
    pending_scores.insert(pending_scores.size(), e);
    pixels_sent++;
    if (e.valid) valid_scores++;
  endtask

  // let everything drain, then allow the pipeline latency to pass
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(ctbf_pkg::cfg_reg_t idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ctbf_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      ctbf_pkg::REG_FRAME_WIDTH:  reg_width  = val & 12'h7ff;
      ctbf_pkg::REG_FRAME_HEIGHT: reg_height = val & 13'h1fff;
      ctbf_pkg::REG_WINDOW_SIZE:  reg_window = val & 6'h3f;
      ctbf_pkg::REG_CORNER_SIZE:  reg_corner = val & 6'h3f;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned ws, int unsigned cs);
    wait_idle();
    write_reg(ctbf_pkg::REG_FRAME_WIDTH, w);
    write_reg(ctbf_pkg::REG_FRAME_HEIGHT, h);
    write_reg(ctbf_pkg::REG_WINDOW_SIZE, ws);
    write_reg(ctbf_pkg::REG_CORNER_SIZE, cs);
    cfg_write <= 1'b0;
  endtask

  task automatic send_frames(int nframes, fill_t mode);
    int unsigned w, h;
    bit [15:0]   pix;
    w = clamp_u(reg_width, 1, ctbf_pkg::MAX_LINE_WIDTH);
    h = clamp_u(reg_height, 1, ctbf_pkg::MAX_FRAME_HEIGHT);
    repeat (nframes) begin
      for (int i = 0; i < w * h; i++) begin
        case (mode)
          FILL_FULL:    pix = 16'hffff;
          FILL_ZERO:    pix = 16'h0000;
          FILL_EXTREME: pix = $urandom_range(0, 1) ? 16'hffff : 16'($urandom);
          default:      pix = 16'($urandom);
        endcase
        send_pixel(pix);
      end
      frames_done++;
    end
  endtask

  // degenerate frames: zero width and height act as one pixel per frame, then a single-column frame
  task automatic test_tiny_frames();
    set_geometry(0, 0, 15, 5);
    send_pixel(16'h0000);
    send_pixel(16'hffff);
    send_pixel(16'h8001);
    set_geometry(1, 3, 2, 1);
    send_frames(1, FILL_RANDOM);
  endtask

  // full-scale input, zero input, and corner of zero
  task automatic test_full_scale();
    set_geometry(4, 4, 2, 1);
    send_frames(1, FILL_FULL);
    set_geometry(5, 3, 3, 0);
    send_frames(1, FILL_ZERO);
  endtask

  // corners as large as the window, and a window above the maximum that saturates:
  // the overlaps give the most negative score
  task automatic test_corner_overlap();
    set_geometry(6, 6, 4, 63);
    send_frames(1, FILL_FULL);
    set_geometry(33, 33, 63, 63);
    send_frames(1, FILL_FULL);
  endtask

  // window zero acts as one
  task automatic test_window_limits();
    set_geometry(7, 5, 0, 1);
    send_frames(1, FILL_RANDOM);
  endtask

  // long line with width and height past their limits, then a narrower width
  // written mid-row so the column counter wraps at once
  task automatic test_wide_line();
    set_geometry(12'h7ff, 13'h1fff, 1, 1);
    for (int i = 0; i < 160; i++) send_pixel(16'($urandom));
    set_geometry(8, 3, 2, 1);
    for (int i = 0; i < 17; i++) send_pixel(16'($urandom));
    frames_done++;
  endtask

  // random small geometries with random content
  task automatic test_random_frames(int target);
    int unsigned w, h, ws, cs;
    while (pixels_sent < target) begin
      w  = $urandom_range(2, 12);
      h  = $urandom_range(2, 8);
      ws = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 8);
      cs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, ws);
      if (pixels_sent > target - 300) quiet = 1'b1;
      set_geometry(w, h, ws, cs);
      send_frames(1, ($urandom_range(0, 7) == 0) ? FILL_EXTREME : FILL_RANDOM);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = ctbf_pkg::REG_FRAME_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pixel        = '0;
    errors       = 0;
    pixels_sent  = 0;
    results_seen = 0;
    valid_scores = 0;
    frames_done  = 0;
    idle_cycles  = 0;
    quiet        = 1'b0;
    reg_width    = 1024;
    reg_height   = 1024;
    reg_window   = 15;
    reg_corner   = 5;
    next_col     = 0;
    next_row     = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_tiny_frames();
    test_full_scale();
    test_corner_overlap();
    test_window_limits();
    test_wide_line();
    test_random_frames(1450);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d pixels in %0d frames, %0d results with %0d valid scores",
             pixels_sent, frames_done, results_seen, valid_scores);
    $display("frames from one pixel to 33 by 33 plus a 1024-wide line, windows 1..32, corners 0..32");
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("cross_template_box_filter_core test passed");
    end else begin
      $display("cross_template_box_filter_core test failed");
    end
    $finish;
  end

endmodule

/* cross_template_box_filter_core.f */
rtl/core/ctbf_pkg.sv
rtl/core/ctbf_queue.sv
rtl/core/ctbf_front.sv
rtl/core/ctbf_back.sv
rtl/core/cross_template_box_filter_core.sv
verif/testbench.sv
